### hw/rtl/jahm_pkg.sv
// ----------------------------------------------------------------------------
// jahm_pkg: shared types and constants of the jump airtime height meter
// Phase and sequencer codes, register indexes, field widths, the height
// scale factor and the mode code mapping.
// ----------------------------------------------------------------------------
package jahm_pkg;

    // Field widths
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned DIST_W   = 13;
    localparam int unsigned AIR_W    = 16;
    localparam int unsigned HEIGHT_W = 21;
    localparam int unsigned CODE_W   = 32;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned CFG_IDX_W = 3;

    // Shift-add multiplier: multiplicand up to 32 bits, multiplier 16 bits
    localparam int unsigned MUL_A_W = 32;
    localparam int unsigned MUL_B_W = 16;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int unsigned MUL_STEP_W = $clog2(MUL_B_W);

    // Height = (air * air * HEIGHT_MUL) >> HEIGHT_SHIFT
    localparam logic [MUL_B_W-1:0] HEIGHT_MUL = 16'd8100;
    localparam int unsigned HEIGHT_SHIFT = 24;

    // Register reset values
    localparam logic [DIST_W-1:0] READY_ZONE_RST   = 13'd610;
    localparam logic [DIST_W-1:0] GONE_MARGIN_RST  = 13'd150;
    localparam logic [AIR_W-1:0]  MIN_AIRTIME_RST  = 16'd120;
    localparam logic [CNT_W-1:0]  STABLE_RST       = 4'd2;
    localparam logic [CODE_W-1:0] REMOTE_CODE_RST  = 32'hE916FF00;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_READY_ZONE  = 3'd0,
        CFG_GONE_MARGIN = 3'd1,
        CFG_MIN_AIRTIME = 3'd2,
        CFG_STABLE      = 3'd3,
        CFG_REMOTE_CODE = 3'd4
    } cfg_idx_t;

    // Mode codes on the result word
    localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WAIT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READY  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_AIR    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RESULT = 3'd4;

    // Measurement phase
    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_WAIT   = 5'b00010,
        PH_READY  = 5'b00100,
        PH_AIR    = 5'b01000,
        PH_RESULT = 5'b10000
    } phase_t;

    // Top-level sequencer
    typedef enum logic [3:0] {
        SQ_IDLE   = 4'b0001,
        SQ_SQUARE = 4'b0010,
        SQ_SCALE  = 4'b0100,
        SQ_PUSH   = 4'b1000
    } seq_t;

    // Configuration as seen by the tracker
    typedef struct packed {
        logic [DIST_W-1:0] ready_zone;
        logic [DIST_W-1:0] gone_margin;
        logic [AIR_W-1:0]  min_airtime;
        logic [CNT_W-1:0]  stable;
        logic [CODE_W-1:0] remote_code;
    } cfg_t;

    // Per-word decision from the tracker
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              white;
        logic              green;
        logic              landed;
        logic              too_short;
        logic [AIR_W-1:0]  air;
        logic              need_height;
    } dec_t;

    // Multiplier status
    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    function automatic logic [MODE_W-1:0] phase_mode(input phase_t ph);
        logic [MODE_W-1:0] m;
        unique case (ph)
            PH_IDLE:   m = MODE_IDLE;
            PH_WAIT:   m = MODE_WAIT;
            PH_READY:  m = MODE_READY;
            PH_AIR:    m = MODE_AIR;
            PH_RESULT: m = MODE_RESULT;
            default:   m = MODE_IDLE;
        endcase
        return m;
    endfunction

endpackage

### hw/rtl/jahm_mul.sv
// ----------------------------------------------------------------------------
// jahm_mul: shift-add multiplier
// One conditional add of the shifted multiplicand per cycle, one per
// multiplier bit; the full product is flagged by a one-cycle done pulse.
// ----------------------------------------------------------------------------
module jahm_mul (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [jahm_pkg::MUL_A_W-1:0]     a,
    input  logic [jahm_pkg::MUL_B_W-1:0]     b,
    output logic [jahm_pkg::MUL_P_W-1:0]     product,
    output jahm_pkg::mul_stat_t              stat
);

    logic [jahm_pkg::MUL_P_W-1:0]    acc_reg, acc_next;
    logic [jahm_pkg::MUL_P_W-1:0]    mcand_reg, mcand_next;
    logic [jahm_pkg::MUL_B_W-1:0]    mplier_reg, mplier_next;
    logic [jahm_pkg::MUL_STEP_W-1:0] step_reg, step_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;

    localparam logic [jahm_pkg::MUL_STEP_W-1:0] LAST_STEP =
        jahm_pkg::MUL_STEP_W'(jahm_pkg::MUL_B_W - 1);

    // Load operands on start, then add and shift once per cycle
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[jahm_pkg::MUL_P_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[jahm_pkg::MUL_B_W-1:1]};
            step_next   = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            acc_next    = '0;
            mcand_next  = {{jahm_pkg::MUL_B_W{1'b0}}, a};
            mplier_next = b;
            step_next   = '0;
            busy_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath needs no reset
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### hw/rtl/jahm_track.sv
// ----------------------------------------------------------------------------
// jahm_track: measurement phase tracker
// Detects the start trigger, debounces zone samples and walks the phases
// from waiting through ready and in-air to result. Its state advances on
// each accepted word; the decision for that word is combinational.
// ----------------------------------------------------------------------------
module jahm_track (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  jahm_pkg::cfg_t                    cfg,
    input  logic [jahm_pkg::TIME_W-1:0]       time_ms,
    input  logic [jahm_pkg::DIST_W-1:0]       distance_mm,
    input  logic                              range_fail,
    input  logic                              button_level,
    input  logic                              remote_valid,
    input  logic [jahm_pkg::CODE_W-1:0]       remote_code,
    output jahm_pkg::dec_t                    dec
);

    jahm_pkg::phase_t              phase_reg, phase_next, phase_trig;
    logic [jahm_pkg::CNT_W-1:0]    agree_reg, agree_next, agree_inc;
    logic [jahm_pkg::TIME_W-1:0]   stamp_reg, stamp_next;
    logic                          btn_prev_reg, btn_prev_next;
    logic                          armed_reg, armed_next;
    logic                          white_reg, white_next;
    logic                          green_reg, green_next;

    logic                          pressed;
    logic                          remote_hit;
    logic                          in_zone;
    logic                          gone;
    logic [jahm_pkg::DIST_W:0]     gone_limit;
    logic                          agree_ok;
    logic                          agree_hit;
    logic [jahm_pkg::TIME_W-1:0]   dt;
    logic [jahm_pkg::AIR_W-1:0]    air;
    logic                          landed;
    logic                          too_short;

    // Button edge while armed, remote code match
    always_comb
    begin
        pressed    = armed_reg && btn_prev_reg && !button_level;
        armed_next = button_level ? 1'b1 : (pressed ? 1'b0 : armed_reg);
        btn_prev_next = button_level;
        remote_hit = remote_valid && (remote_code != '0) && (remote_code != '1) &&
                     (remote_code == cfg.remote_code);
    end

    // Zone classification of the sample
    always_comb
    begin
        gone_limit = {1'b0, cfg.ready_zone} + {1'b0, cfg.gone_margin};
        in_zone    = !range_fail && (distance_mm != '0) && (distance_mm <= cfg.ready_zone);
        gone       = range_fail || ({1'b0, distance_mm} > gone_limit);
    end

    // Airtime since takeoff, saturated
    always_comb
    begin
        dt        = time_ms - stamp_reg;
        air       = (dt[jahm_pkg::TIME_W-1:jahm_pkg::AIR_W] != '0) ? '1
                                                              : dt[jahm_pkg::AIR_W-1:0];
        too_short = dt < {{(jahm_pkg::TIME_W - jahm_pkg::AIR_W){1'b0}}, cfg.min_airtime};
    end

    // Trigger, then judge the sample in the resulting phase
    always_comb
    begin
        phase_trig = phase_reg;
        white_next = white_reg;
        green_next = green_reg;
        stamp_next = stamp_reg;
        landed     = 1'b0;
        if ((pressed || remote_hit) &&
            (phase_reg == jahm_pkg::PH_IDLE || phase_reg == jahm_pkg::PH_RESULT))
        begin
            phase_trig = jahm_pkg::PH_WAIT;
            white_next = 1'b1;
            green_next = 1'b0;
        end
        phase_next = phase_trig;

        unique case (phase_trig)
            jahm_pkg::PH_WAIT:  agree_ok = in_zone;
            jahm_pkg::PH_READY: agree_ok = gone;
            jahm_pkg::PH_AIR:   agree_ok = in_zone;
            default:            agree_ok = 1'b0;
        endcase

        // Count agreeing samples, saturating at the counter top
        agree_inc = (agree_reg != '1) ? agree_reg + 1'b1 : agree_reg;
        agree_hit = 1'b0;
        agree_next = agree_reg;
        if (phase_trig == jahm_pkg::PH_WAIT || phase_trig == jahm_pkg::PH_READY ||
            phase_trig == jahm_pkg::PH_AIR)
        begin
            if (!agree_ok)
            begin
                agree_next = '0;
            end
            else if (agree_inc >= cfg.stable)
            begin
                agree_next = '0;
                agree_hit  = 1'b1;
            end
            else
            begin
                agree_next = agree_inc;
            end
        end

        if (agree_hit)
        begin
            unique case (phase_trig)
                jahm_pkg::PH_WAIT:
                begin
                    phase_next = jahm_pkg::PH_READY;
                    white_next = 1'b0;
                    green_next = 1'b1;
                end
                jahm_pkg::PH_READY:
                begin
                    phase_next = jahm_pkg::PH_AIR;
                    stamp_next = time_ms;
                    white_next = 1'b0;
                    green_next = 1'b1;
                end
                jahm_pkg::PH_AIR:
                begin
                    phase_next = jahm_pkg::PH_RESULT;
                    white_next = 1'b0;
                    green_next = 1'b0;
                    landed     = 1'b1;
                end
                default:
                begin
                    phase_next = phase_trig;
                end
            endcase
        end
    end

    // Decision word for this sample
    always_comb
    begin
        dec.mode        = jahm_pkg::phase_mode(phase_next);
        dec.white       = white_next;
        dec.green       = green_next;
        dec.landed      = landed;
        dec.too_short   = landed && too_short;
        dec.air         = landed ? air : '0;
        dec.need_height = landed && !too_short;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= jahm_pkg::PH_IDLE;
            agree_reg    <= '0;
            stamp_reg    <= '0;
            btn_prev_reg <= 1'b1;
            armed_reg    <= 1'b1;
            white_reg    <= 1'b0;
            green_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            agree_reg    <= agree_next;
            stamp_reg    <= stamp_next;
            btn_prev_reg <= btn_prev_next;
            armed_reg    <= armed_next;
            white_reg    <= white_next;
            green_reg    <= green_next;
        end
    end

endmodule

### hw/rtl/jump_airtime_height_meter.sv
// ----------------------------------------------------------------------------
// jump_airtime_height_meter: jump airtime and height meter
// Each input word is one sensor tick; each yields one result word.
// ----------------------------------------------------------------------------
// One input word produces one result word. A word whose tick confirms a
// valid landing has its height (airtime squared times 8100, shifted right
// by 24) run through one shared shift-add multiplier twice, 16 add-shift
// steps each, and then moves into the output register; any other word
// moves there directly. Either way the word waits while the output
// register stays full. in_stall stays high from acceptance until the
// result is moved into the output register, which may still be waiting
// to be taken while the next word is accepted.
module jump_airtime_height_meter (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [jahm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jahm_pkg::CFG_W-1:0]        cfg_data,
    // Input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [jahm_pkg::TIME_W-1:0]       time_ms,
    input  logic [jahm_pkg::DIST_W-1:0]       distance_mm,
    input  logic                              range_fail,
    input  logic                              button_level,
    input  logic                              remote_valid,
    input  logic [jahm_pkg::CODE_W-1:0]       remote_code,
    // Output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [jahm_pkg::MODE_W-1:0]       mode,
    output logic                              wait_lamp,
    output logic                              active_lamp,
    output logic                              landed,
    output logic                              too_short,
    output logic [jahm_pkg::AIR_W-1:0]        airtime_ms,
    output logic [jahm_pkg::HEIGHT_W-1:0]     height_tenths_in
);

    jahm_pkg::cfg_t                  cfg_reg;
    jahm_pkg::seq_t                  seq_reg, seq_next;
    jahm_pkg::dec_t                  dec;
    jahm_pkg::dec_t                  pend_reg, pend_next;
    logic [jahm_pkg::HEIGHT_W-1:0]   pend_height_reg, pend_height_next;

    logic                            in_take;
    logic                            out_free;

    logic                            mul_start;
    logic [jahm_pkg::MUL_A_W-1:0]    mul_a;
    logic [jahm_pkg::MUL_B_W-1:0]    mul_b;
    logic [jahm_pkg::MUL_P_W-1:0]    mul_p;
    jahm_pkg::mul_stat_t             mul_stat;

    logic                            out_valid_reg, out_valid_next;
    jahm_pkg::dec_t                  out_reg, out_next;
    logic [jahm_pkg::HEIGHT_W-1:0]   out_height_reg, out_height_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ready_zone  <= jahm_pkg::READY_ZONE_RST;
            cfg_reg.gone_margin <= jahm_pkg::GONE_MARGIN_RST;
            cfg_reg.min_airtime <= jahm_pkg::MIN_AIRTIME_RST;
            cfg_reg.stable      <= jahm_pkg::STABLE_RST;
            cfg_reg.remote_code <= jahm_pkg::REMOTE_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                jahm_pkg::CFG_READY_ZONE:
                    cfg_reg.ready_zone  <= cfg_data[jahm_pkg::DIST_W-1:0];
                jahm_pkg::CFG_GONE_MARGIN:
                    cfg_reg.gone_margin <= cfg_data[jahm_pkg::DIST_W-1:0];
                jahm_pkg::CFG_MIN_AIRTIME:
                    cfg_reg.min_airtime <= cfg_data[jahm_pkg::AIR_W-1:0];
                jahm_pkg::CFG_STABLE:
                    cfg_reg.stable      <= cfg_data[jahm_pkg::CNT_W-1:0];
                jahm_pkg::CFG_REMOTE_CODE:
                    cfg_reg.remote_code <= cfg_data[jahm_pkg::CODE_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_stall = (seq_reg != jahm_pkg::SQ_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    jahm_track u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (in_take),
        .cfg          (cfg_reg),
        .time_ms      (time_ms),
        .distance_mm  (distance_mm),
        .range_fail   (range_fail),
        .button_level (button_level),
        .remote_valid (remote_valid),
        .remote_code  (remote_code),
        .dec          (dec)
    );

    jahm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p),
        .stat    (mul_stat)
    );

    // Sequencer: accept, square, scale, push
    always_comb
    begin
        seq_next         = seq_reg;
        pend_next        = pend_reg;
        pend_height_next = pend_height_reg;
        mul_start        = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        out_valid_next   = out_valid_reg && out_stall;
        out_next         = out_reg;
        out_height_next  = out_height_reg;

        unique case (seq_reg)
            jahm_pkg::SQ_IDLE:
            begin
                if (in_take)
                begin
                    pend_next        = dec;
                    pend_height_next = '0;
                    if (dec.need_height)
                    begin
                        mul_start = 1'b1;
                        mul_a     = {{(jahm_pkg::MUL_A_W - jahm_pkg::AIR_W){1'b0}}, dec.air};
                        mul_b     = dec.air;
                        seq_next  = jahm_pkg::SQ_SQUARE;
                    end
                    else
                    begin
                        seq_next = jahm_pkg::SQ_PUSH;
                    end
                end
            end
            jahm_pkg::SQ_SQUARE:
            begin
                // Square fits in 32 bits; scale it next
                if (mul_stat.done)
                begin
                    mul_start = 1'b1;
                    mul_a     = mul_p[jahm_pkg::MUL_A_W-1:0];
                    mul_b     = jahm_pkg::HEIGHT_MUL;
                    seq_next  = jahm_pkg::SQ_SCALE;
                end
            end
            jahm_pkg::SQ_SCALE:
            begin
                if (mul_stat.done)
                begin
                    pend_height_next =
                        mul_p[jahm_pkg::HEIGHT_SHIFT +: jahm_pkg::HEIGHT_W];
                    seq_next = jahm_pkg::SQ_PUSH;
                end
            end
            jahm_pkg::SQ_PUSH:
            begin
                // Move the word into the output register once it is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_height_next = pend_height_reg;
                    seq_next        = jahm_pkg::SQ_IDLE;
                end
            end
            default:
            begin
                seq_next = jahm_pkg::SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= jahm_pkg::SQ_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge clk)
    begin
        pend_reg        <= pend_next;
        pend_height_reg <= pend_height_next;
        out_reg         <= out_next;
        out_height_reg  <= out_height_next;
    end

    assign out_valid        = out_valid_reg;
    assign mode             = out_reg.mode;
    assign wait_lamp        = out_reg.white;
    assign active_lamp      = out_reg.green;
    assign landed           = out_reg.landed;
    assign too_short        = out_reg.too_short;
    assign airtime_ms       = out_reg.air;
    assign height_tenths_in = out_height_reg;

`ifndef SYNTHESIS
    // An accepted word always keeps the input side closed for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a word is still in work");

    // Multiplier finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> (seq_reg == jahm_pkg::SQ_SQUARE || seq_reg == jahm_pkg::SQ_SCALE))
        else $error("multiplier result with no consumer");

    // A short jump reports no height
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && too_short |-> height_tenths_in == '0 && landed)
        else $error("too short result carries a height");

    // No airtime unless landed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !landed |-> airtime_ms == '0 && height_tenths_in == '0)
        else $error("measurement fields set without landing");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the jump airtime height meter
// A short directed run covers the edge cases: timestamp wrap, saturated
// airtime, too-short jumps, zero distance, ignored triggers and remote codes
// that never match. Random measurement sequences and noise then follow under
// six register settings. Both handshakes idle at random. A scoreboard
// predicts every result word from the accepted input words and compares it
// field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import jahm_pkg::*;

    localparam int unsigned SCALE_MUL   = 8100;
    localparam int unsigned SCALE_SHIFT = 24;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASE_WORDS = 250;
    localparam longint     LIMIT_NS    = 10_000_000;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [DIST_W-1:0] range_mm;
        logic              fail;
        logic              button;
        logic              rvalid;
        logic [CODE_W-1:0] rcode;
    } tick_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic                white;
        logic                green;
        logic                landed;
        logic                too_short;
        logic [AIR_W-1:0]    air;
        logic [HEIGHT_W-1:0] height;
    } result_t;

    typedef enum int {D_IN, D_GONE, D_MID} zone_kind_t;

    // Scoreboard: tracks the meter state and holds the expected result words
    class jump_scoreboard;
        logic [DIST_W-1:0] zone;
        logic [DIST_W-1:0] margin;
        logic [AIR_W-1:0]  min_air;
        logic [CNT_W-1:0]  stable;
        logic [CODE_W-1:0] start_code;

        logic [MODE_W-1:0] phase;
        logic [CNT_W-1:0]  agree_cnt;
        logic [TIME_W-1:0] takeoff_ms;
        bit                btn_prev;
        bit                btn_armed;
        bit                white;
        bit                green;

        result_t expected_words[$];
        int      mismatches;
        int      checked;
        int      landings;
        int      short_jumps;
        int      saturated;

        function new();
            zone       = 13'd610;
            margin     = 13'd150;
            min_air    = 16'd120;
            stable     = 4'd2;
            start_code = 32'hE916FF00;
            phase      = MODE_IDLE;
            agree_cnt  = '0;
            takeoff_ms = '0;
            btn_prev   = 1'b1;
            btn_armed  = 1'b1;
            white      = 1'b0;
            green      = 1'b0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_READY_ZONE:  zone       = value[DIST_W-1:0];
                CFG_GONE_MARGIN: margin     = value[DIST_W-1:0];
                CFG_MIN_AIRTIME: min_air    = value[AIR_W-1:0];
                CFG_STABLE:      stable     = value[CNT_W-1:0];
                CFG_REMOTE_CODE: start_code = value[CODE_W-1:0];
                default: ;
            endcase
        endfunction

        // Count one agreeing sample; true once the threshold is reached
        function bit count_agree(bit ok);
            if (!ok)
            begin
                agree_cnt = '0;
                return 1'b0;
            end
            if (agree_cnt < 4'd15)
                agree_cnt++;
            if (agree_cnt >= stable)
            begin
                agree_cnt = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function result_t predict_tick(tick_t t);
            result_t           r;
            bit                pressed;
            bit                remote;
            bit                in_zone;
            bit                gone;
            logic [TIME_W-1:0] dt;
            logic [63:0]       prod;
            r = '0;
            pressed = 1'b0;
            // Falling button edge, armed only after a release
            if (btn_armed && btn_prev && !t.button)
            begin
                pressed = 1'b1;
                btn_armed = 1'b0;
            end
            if (t.button)
                btn_armed = 1'b1;
            btn_prev = t.button;
            remote = t.rvalid && t.rcode != '0 && t.rcode != '1 && t.rcode == start_code;
            if ((pressed || remote) && (phase == MODE_IDLE || phase == MODE_RESULT))
            begin
                phase = MODE_WAIT;
                white = 1'b1;
                green = 1'b0;
            end
            in_zone = !t.fail && t.range_mm != '0 && t.range_mm <= zone;
            gone = t.fail || ({1'b0, t.range_mm} > ({1'b0, zone} + {1'b0, margin}));
            case (phase)
                MODE_WAIT:
                    if (count_agree(in_zone))
                    begin
                        phase = MODE_READY;
                        white = 1'b0;
                        green = 1'b1;
                    end
                MODE_READY:
                    if (count_agree(gone))
                    begin
                        phase = MODE_AIR;
                        takeoff_ms = t.time_ms;
                        white = 1'b0;
                        green = 1'b1;
                    end
                MODE_AIR:
                    if (count_agree(in_zone))
                    begin
                        dt = t.time_ms - takeoff_ms;
                        white = 1'b0;
                        green = 1'b0;
                        r.landed = 1'b1;
                        r.air = (dt > 32'hFFFF) ? 16'hFFFF : dt[AIR_W-1:0];
                        if (dt < {16'd0, min_air})
                        begin
                            r.too_short = 1'b1;
                        end
                        else
                        begin
                            prod = 64'(r.air) * 64'(r.air) * 64'(SCALE_MUL);
                            r.height = HEIGHT_W'(prod >> SCALE_SHIFT);
                        end
                        phase = MODE_RESULT;
                    end
                default: ;
            endcase
            r.mode  = phase;
            r.white = white;
            r.green = green;
            return r;
        endfunction

        function void note_tick(tick_t t);
            expected_words.push_back(predict_tick(t));
        endfunction

        task report(string msg);
            mismatches++;
            $display("ERROR at %0t: %s", $realtime, msg);
        endtask

        task cmp_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("word %0d %s: got %0h, expected %0h",
                                 checked, name, got, want));
        endtask

        task check_word(result_t got);
            result_t want;
            if (expected_words.size() == 0)
            begin
                report("result word with nothing expected");
                return;
            end
            want = expected_words.pop_front();
            cmp_field("mode", 32'(got.mode), 32'(want.mode));
            cmp_field("wait_lamp", 32'(got.white), 32'(want.white));
            cmp_field("active_lamp", 32'(got.green), 32'(want.green));
            cmp_field("landed", 32'(got.landed), 32'(want.landed));
            cmp_field("too_short", 32'(got.too_short), 32'(want.too_short));
            cmp_field("airtime_ms", 32'(got.air), 32'(want.air));
            cmp_field("height_tenths_in", 32'(got.height), 32'(want.height));
            if (want.landed)
            begin
                landings++;
                if (want.too_short)
                    short_jumps++;
                if (want.air == 16'hFFFF)
                    saturated++;
            end
            checked++;
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [TIME_W-1:0]   time_ms;
    logic [DIST_W-1:0]   distance_mm;
    logic                range_fail;
    logic                button_level;
    logic                remote_valid;
    logic [CODE_W-1:0]   remote_code;
    logic                out_valid;
    logic                out_stall;
    logic [MODE_W-1:0]   mode;
    logic                wait_lamp;
    logic                active_lamp;
    logic                landed;
    logic                too_short;
    logic [AIR_W-1:0]    airtime_ms;
    logic [HEIGHT_W-1:0] height_tenths_in;

    jump_scoreboard sb = new();

    // Stimulus bookkeeping
    logic [TIME_W-1:0] now_ms = '0;
    logic [DIST_W-1:0] cur_zone = 13'd610;
    logic [DIST_W-1:0] cur_margin = 13'd150;
    logic [CNT_W-1:0]  cur_stable = 4'd2;
    logic [CODE_W-1:0] cur_code = 32'hE916FF00;
    bit                btn_level = 1'b1;
    bit                quiet_in = 1'b0;
    bit                quiet_out = 1'b0;
    bit                hold_req = 1'b0;
    int                words_sent = 0;
    int                settings_used = 0;
    int                holds = 0;

    jump_airtime_height_meter dut (.*);

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor both channels
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_tick({time_ms, distance_mm, range_fail, button_level,
                          remote_valid, remote_code});
        if (rst_n && out_valid && !out_stall)
            sb.check_word({mode, wait_lamp, active_lamp, landed, too_short,
                           airtime_ms, height_tenths_in});
    end

    // Offer one input word after a random gap and wait until it is taken
    task automatic send_tick(input tick_t t);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        time_ms      <= t.time_ms;
        distance_mm  <= t.range_mm;
        range_fail   <= t.fail;
        button_level <= t.button;
        remote_valid <= t.rvalid;
        remote_code  <= t.rcode;
        btn_level = t.button;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    // Drop valid and hold until every expected word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    // Program all five registers for one phase of the random run
    task automatic load_setting(input int p);
        logic [CFG_W-1:0] z;
        logic [CFG_W-1:0] m;
        logic [CFG_W-1:0] ma;
        logic [CFG_W-1:0] st;
        logic [CFG_W-1:0] code;
        case (p)
            0:
            begin
                z = 32'd610;
                m = 32'd150;
                ma = 32'd120;
                st = 32'd2;
                code = 32'hE916FF00;
            end
            1:
            begin
                z = 32'd8191;
                m = 32'd8191;
                ma = 32'd0;
                st = 32'd1;
                code = '1;
            end
            2:
            begin
                z = 32'd1;
                m = 32'd0;
                ma = 32'd65535;
                st = 32'd15;
                code = '0;
            end
            3:
            begin
                z = $urandom_range(1, 2000);
                m = $urandom_range(0, 2000);
                ma = $urandom_range(0, 600);
                st = 32'd0;
                code = $urandom;
            end
            default:
            begin
                z = $urandom_range(1, 8191);
                m = $urandom_range(0, 8191);
                ma = $urandom_range(0, 1000);
                st = $urandom_range(0, 15);
                code = $urandom;
            end
        endcase
        wait_drained();
        write_reg(CFG_READY_ZONE, z);
        write_reg(CFG_GONE_MARGIN, m);
        write_reg(CFG_MIN_AIRTIME, ma);
        write_reg(CFG_STABLE, st);
        write_reg(CFG_REMOTE_CODE, code);
        cfg_we <= 1'b0;
        cur_zone   = z[DIST_W-1:0];
        cur_margin = m[DIST_W-1:0];
        cur_stable = st[CNT_W-1:0];
        cur_code   = code;
        settings_used++;
        // Start phase 2 just short of the timestamp wrap
        now_ms = (p == 2) ? 32'hFFFF_F000 + $urandom_range(0, 2048) : $urandom;
    endtask

    function automatic logic [CODE_W-1:0] noise_code();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return cur_code;
            default: return $urandom;
        endcase
    endfunction

    // Build a word whose distance lands in the requested region
    function automatic tick_t shape_tick(input zone_kind_t k, input bit btn,
                                         input bit rv, input logic [CODE_W-1:0] rc);
        tick_t t;
        int    lim;
        lim = int'(cur_zone) + int'(cur_margin);
        t.time_ms = now_ms;
        t.fail    = 1'b0;
        t.button  = btn;
        t.rvalid  = rv;
        t.rcode   = rv ? rc : $urandom;
        case (k)
            D_IN: t.range_mm = DIST_W'($urandom_range(1, int'(cur_zone)));
            D_GONE:
                if (lim >= 8191 || $urandom_range(0, 3) == 0)
                begin
                    t.fail = 1'b1;
                    t.range_mm = DIST_W'($urandom);
                end
                else
                begin
                    t.range_mm = DIST_W'($urandom_range(lim + 1, 8191));
                end
            default:
                if (cur_zone == 13'h1FFF || cur_margin == '0 || $urandom_range(0, 2) == 0)
                    t.range_mm = '0;
                else
                    t.range_mm = DIST_W'($urandom_range(int'(cur_zone) + 1,
                                                        (lim > 8191) ? 8191 : lim));
        endcase
        return t;
    endfunction

    // One sensor tick with occasional distance, button and remote noise
    task automatic tick(input zone_kind_t kind, input bit btn);
        tick_t t;
        zone_kind_t k;
        bit b;
        k = kind;
        b = btn;
        if ($urandom_range(0, 11) == 0)
            k = zone_kind_t'($urandom_range(0, 2));
        if ($urandom_range(0, 24) == 0)
            b = !b;
        t = shape_tick(k, b, 1'b0, '0);
        if ($urandom_range(0, 19) == 0)
        begin
            t.rvalid = 1'b1;
            t.rcode  = noise_code();
        end
        send_tick(t);
        now_ms += $urandom_range(0, 40);
    endtask

    // Start, settle in the zone, take off, stay out, land, linger
    task automatic jump_sequence();
        if ($urandom_range(0, 1) == 1)
        begin
            if (!btn_level)
                tick(D_MID, 1'b1);
            tick(D_IN, 1'b0);
        end
        else
        begin
            send_tick(shape_tick(D_IN, btn_level, 1'b1, cur_code));
            now_ms += $urandom_range(0, 40);
        end
        repeat (int'(cur_stable) + $urandom_range(0, 2)) tick(D_IN, 1'b1);
        repeat (int'(cur_stable) + $urandom_range(0, 2)) tick(D_GONE, 1'b1);
        repeat ($urandom_range(0, 30))
            tick(($urandom_range(0, 3) == 0) ? D_MID : D_GONE, 1'b1);
        if ($urandom_range(0, 7) == 0)
            now_ms += $urandom_range(0, 80000);
        repeat (int'(cur_stable) + $urandom_range(0, 2)) tick(D_IN, 1'b1);
        repeat ($urandom_range(0, 3)) tick(zone_kind_t'($urandom_range(0, 2)), 1'b1);
    endtask

    task automatic noise_burst();
        tick_t t;
        repeat ($urandom_range(1, 20))
        begin
            t = shape_tick(zone_kind_t'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), noise_code());
            if ($urandom_range(0, 15) == 0)
                t.time_ms = $urandom;
            send_tick(t);
            now_ms += $urandom_range(0, 40);
        end
    endtask

    function automatic tick_t mk(input logic [TIME_W-1:0] tm, input logic [DIST_W-1:0] d,
                                 input bit f, input bit b, input bit rv,
                                 input logic [CODE_W-1:0] rc);
        return {tm, d, f, b, rv, rc};
    endfunction

    // Directed edge cases under the reset register values
    task automatic run_directed();
        // idle, nothing starts; codes 0 and all ones never match
        send_tick(mk(32'd0, 13'd0, 1'b0, 1'b1, 1'b1, 32'h0));
        send_tick(mk(32'd20, 13'd8191, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF));
        // button press starts; zero distance breaks the count
        send_tick(mk(32'd40, 13'd300, 1'b0, 1'b0, 1'b0, 32'h1234_5678));
        send_tick(mk(32'd60, 13'd0, 1'b0, 1'b0, 1'b0, 32'h0));
        // remote and button triggers while measuring are ignored
        send_tick(mk(32'd80, 13'd610, 1'b0, 1'b1, 1'b1, 32'hE916FF00));
        send_tick(mk(32'd100, 13'd1, 1'b0, 1'b0, 1'b0, 32'h0));
        // takeoff just before the timestamp wraps
        send_tick(mk(32'd120, 13'd5, 1'b1, 1'b1, 1'b0, 32'h0));
        send_tick(mk(32'hFFFF_FFF0, 13'd761, 1'b0, 1'b1, 1'b0, 32'h0));
        // inside the margin: neither in the zone nor gone
        send_tick(mk(32'hFFFF_FFFF, 13'd760, 1'b0, 1'b1, 1'b0, 32'h0));
        // landing after the wrap, too short
        send_tick(mk(32'h0000_0010, 13'd609, 1'b0, 1'b1, 1'b0, 32'h0));
        send_tick(mk(32'h0000_0020, 13'd609, 1'b0, 1'b1, 1'b0, 32'h0));
        send_tick(mk(32'h0000_0040, 13'd1000, 1'b0, 1'b1, 1'b0, 32'h0));
        // remote start from the result display
        send_tick(mk(32'h0000_0060, 13'd200, 1'b0, 1'b1, 1'b1, 32'hE916FF00));
        send_tick(mk(32'h0000_0080, 13'd200, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF));
        send_tick(mk(32'd1000, 13'd8191, 1'b1, 1'b1, 1'b0, 32'h0));
        send_tick(mk(32'd1020, 13'd0, 1'b1, 1'b1, 1'b0, 32'h0));
        // very long flight saturates the airtime
        send_tick(mk(32'd201020, 13'd610, 1'b0, 1'b1, 1'b0, 32'h0));
        send_tick(mk(32'd201040, 13'd610, 1'b0, 1'b1, 1'b0, 32'h0));
        // ordinary jump with a valid height
        send_tick(mk(32'd201060, 13'd4000, 1'b0, 1'b0, 1'b0, 32'h0));
        send_tick(mk(32'd201080, 13'd100, 1'b0, 1'b0, 1'b0, 32'h0));
        send_tick(mk(32'd201100, 13'd100, 1'b0, 1'b1, 1'b0, 32'h0));
        send_tick(mk(32'd205000, 13'd8000, 1'b0, 1'b1, 1'b0, 32'h0));
        send_tick(mk(32'd205020, 13'd8000, 1'b0, 1'b1, 1'b0, 32'h0));
        send_tick(mk(32'd205520, 13'd300, 1'b0, 1'b1, 1'b0, 32'h0));
        send_tick(mk(32'd205540, 13'd300, 1'b0, 1'b1, 1'b0, 32'h0));
    endtask

    // Result side: random stalls per word, plus one long hold-off on request
    initial
    begin : result_side
        int wait_n;
        bit hold_done;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                quiet_out = !quiet_out;
            wait_n = quiet_out ? 0 : $urandom_range(0, 13);
            if (hold_req && !hold_done)
            begin
                wait_n = HOLD_CYCLES;
                hold_done = 1'b1;
                holds++;
            end
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Main stimulus
    initial
    begin : stimulus
        int base;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_READY_ZONE;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        time_ms      <= '0;
        distance_mm  <= '0;
        range_fail   <= 1'b0;
        button_level <= 1'b1;
        remote_valid <= 1'b0;
        remote_code  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int p = 0; p < 6; p++)
        begin
            load_setting(p);
            // keep offering words while the result side holds off
            if (p == 3)
                hold_req = 1'b1;
            base = words_sent;
            while (words_sent - base < PHASE_WORDS)
            begin
                if ($urandom_range(0, 7) == 0)
                    quiet_in = !quiet_in;
                if ($urandom_range(0, 4) == 0)
                    noise_burst();
                else
                    jump_sequence();
                if ($urandom_range(0, 29) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);

        $display("Run covered %0d input words under %0d register settings, %0d words checked.",
                 words_sent, settings_used, sb.checked);
        $display("Landings: %0d (%0d too short, %0d saturated); long output hold-offs: %0d.",
                 sb.landings, sb.short_jumps, sb.saturated, holds);
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Run limit
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("Run limit reached with %0d words still expected.",
                 sb.expected_words.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
